// ===== rtl/core/fvn_pkg.sv =====
// fvn_pkg: shared constants, hash table and command types for the fractal value noise block
// used by fvn_ctrl, fvn_dp and fractal_value_noise_2d; no dependencies
package fvn_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int LAT_BITS    = 8;
    localparam int POS_W       = LAT_BITS + FRAC_BITS;
    localparam int MAX_OCTAVES = 24;
    localparam int OCT_W       = 5;
    localparam int COORD_W     = 16;
    localparam int FREQ_W      = 24;
    localparam int SEED_W      = 8;
    localparam int NOISE_W     = 16;
    localparam int W_W         = FRAC_BITS + 1;          // weight incl. one
    localparam int BLEND_W     = LAT_BITS + FRAC_BITS + 1;
    localparam int ACC_W       = BLEND_W + 1;
    localparam int AMP_W       = FRAC_BITS + 1;
    localparam int NUM_W       = ACC_W + 8;
    localparam int DCNT_W      = $clog2(NUM_W);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED    = 2'd2;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 24'd655;
    localparam logic [OCT_W-1:0]  OCT_RESET  = 5'd20;
    localparam logic [SEED_W-1:0] SEED_RESET = 8'd42;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCALE,
        CMD_HASH,
        CMD_WEIGHT,
        CMD_BLEND,
        CMD_MIX,
        CMD_ACC,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_OUT
    } t_cmd;

    typedef struct packed {
        logic last_oct;
        logic div_last;
    } t_dp_status;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd208,8'd34,8'd231,8'd213,8'd32,8'd248,8'd233,8'd56,8'd161,8'd78,8'd24,8'd140,
        8'd71,8'd48,8'd140,8'd254,8'd245,8'd255,8'd247,8'd247,8'd40,8'd185,8'd248,8'd251,
        8'd245,8'd28,8'd124,8'd204,8'd204,8'd76,8'd36,8'd1,8'd107,8'd28,8'd234,8'd163,
        8'd202,8'd224,8'd245,8'd128,8'd167,8'd204,8'd9,8'd92,8'd217,8'd54,8'd239,8'd174,
        8'd173,8'd102,8'd193,8'd189,8'd190,8'd121,8'd100,8'd108,8'd167,8'd44,8'd43,8'd77,
        8'd180,8'd204,8'd8,8'd81,8'd70,8'd223,8'd11,8'd38,8'd24,8'd254,8'd210,8'd210,
        8'd177,8'd32,8'd81,8'd195,8'd243,8'd125,8'd8,8'd169,8'd112,8'd32,8'd97,8'd53,
        8'd195,8'd13,8'd203,8'd9,8'd47,8'd104,8'd125,8'd117,8'd114,8'd124,8'd165,8'd203,
        8'd181,8'd235,8'd193,8'd206,8'd70,8'd180,8'd174,8'd0,8'd167,8'd181,8'd41,8'd164,
        8'd30,8'd116,8'd127,8'd198,8'd245,8'd146,8'd87,8'd224,8'd149,8'd206,8'd57,8'd4,
        8'd192,8'd210,8'd65,8'd210,8'd129,8'd240,8'd178,8'd105,8'd228,8'd108,8'd245,8'd148,
        8'd140,8'd40,8'd35,8'd195,8'd38,8'd58,8'd65,8'd207,8'd215,8'd253,8'd65,8'd85,
        8'd208,8'd76,8'd62,8'd3,8'd237,8'd55,8'd89,8'd232,8'd50,8'd217,8'd64,8'd244,
        8'd157,8'd199,8'd121,8'd252,8'd90,8'd17,8'd212,8'd203,8'd149,8'd152,8'd140,8'd187,
        8'd234,8'd177,8'd73,8'd174,8'd193,8'd100,8'd192,8'd143,8'd97,8'd53,8'd145,8'd135,
        8'd19,8'd103,8'd13,8'd90,8'd135,8'd151,8'd199,8'd91,8'd239,8'd247,8'd33,8'd39,
        8'd145,8'd101,8'd120,8'd99,8'd3,8'd186,8'd86,8'd99,8'd41,8'd237,8'd203,8'd111,
        8'd79,8'd220,8'd135,8'd158,8'd42,8'd30,8'd154,8'd120,8'd67,8'd87,8'd167,8'd135,
        8'd176,8'd183,8'd191,8'd253,8'd115,8'd184,8'd21,8'd233,8'd58,8'd129,8'd233,8'd142,
        8'd39,8'd128,8'd211,8'd118,8'd137,8'd139,8'd255,8'd114,8'd20,8'd218,8'd113,8'd154,
        8'd27,8'd127,8'd246,8'd250,8'd1,8'd8,8'd198,8'd250,8'd209,8'd92,8'd222,8'd173,
        8'd21,8'd88,8'd102,8'd219
    };

endpackage

// ===== rtl/core/fvn_ctrl.sv =====
// fvn_ctrl: sequencer for the octave loop and the result divider
// depends on fvn_pkg
module fvn_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_free,
    input  fvn_pkg::t_dp_status i_status,
    output logic               o_in_ready,
    output fvn_pkg::t_cmd      o_cmd
);
    import fvn_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE, S_HASH, S_WEIGHT, S_BLEND, S_MIX, S_ACC, S_DIVI, S_DIV, S_HOLD
    } t_state;

    t_state r_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        unique case (r_state)
            S_IDLE:   o_cmd = i_in_valid ? CMD_LOAD : CMD_NONE;
            S_SCALE:  o_cmd = CMD_SCALE;
            S_HASH:   o_cmd = CMD_HASH;
            S_WEIGHT: o_cmd = CMD_WEIGHT;
            S_BLEND:  o_cmd = CMD_BLEND;
            S_MIX:    o_cmd = CMD_MIX;
            S_ACC:    o_cmd = CMD_ACC;
            S_DIVI:   o_cmd = CMD_DIV_INIT;
            S_DIV:    o_cmd = CMD_DIV_STEP;
            S_HOLD:   o_cmd = i_out_free ? CMD_OUT : CMD_NONE;
            default:  o_cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:   if (i_in_valid) r_state <= S_SCALE;
                S_SCALE:  r_state <= S_HASH;
                S_HASH:   r_state <= S_WEIGHT;
                S_WEIGHT: r_state <= S_BLEND;
                S_BLEND:  r_state <= S_MIX;
                S_MIX:    r_state <= S_ACC;
                S_ACC:    r_state <= i_status.last_oct ? S_DIVI : S_HASH;
                S_DIVI:   r_state <= S_DIV;
                S_DIV:    if (i_status.div_last) r_state <= S_HOLD;
                S_HOLD:   if (i_out_free) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/fvn_dp.sv =====
// fvn_dp: position scaling, hash lookup, smoothstep blend, octave sum and restoring divider
// depends on fvn_pkg
module fvn_dp (
    input  logic                          i_clk,
    input  fvn_pkg::t_cmd                 i_cmd,
    input  logic [fvn_pkg::COORD_W-1:0]   i_x,
    input  logic [fvn_pkg::COORD_W-1:0]   i_y,
    input  logic [fvn_pkg::FREQ_W-1:0]    i_freq,
    input  logic [fvn_pkg::OCT_W-1:0]     i_octaves,
    input  logic [fvn_pkg::SEED_W-1:0]    i_seed,
    output fvn_pkg::t_dp_status           o_status,
    output logic [fvn_pkg::NOISE_W-1:0]   o_noise
);
    import fvn_pkg::*;

    localparam logic [W_W-1:0] ONE = W_W'(1) << FRAC_BITS;

    logic [COORD_W-1:0]   r_x, r_y;
    logic [POS_W-1:0]     r_px, r_py;
    logic [OCT_W-1:0]     r_oct, r_nlim;
    logic [7:0]           r_h0, r_h1;
    logic [FRAC_BITS-1:0] r_sqx, r_sqy;
    logic [7:0]           r_c00, r_c10, r_c01, r_c11;
    logic [W_W-1:0]       r_wx, r_wy;
    logic [BLEND_W-1:0]   r_lo, r_hi, r_v;
    logic [ACC_W-1:0]     r_acc;
    logic [AMP_W-1:0]     r_amp;
    logic [NUM_W-1:0]     r_num;
    logic [AMP_W-1:0]     r_rem;
    logic [DCNT_W-1:0]    r_dcnt;

    logic [7:0]           xi, yi;
    logic [FRAC_BITS-1:0] sx, sy;
    logic [FRAC_BITS+1:0] tailx, taily;
    logic [2*FRAC_BITS+1:0] prodx, prody;
    logic [W_W-1:0]       omx, omy;
    logic [BLEND_W+W_W-1:0] mix;
    logic [AMP_W:0]       trial;
    logic [OCT_W-1:0]     nlim;

    assign xi = r_px[POS_W-1:FRAC_BITS];
    assign yi = r_py[POS_W-1:FRAC_BITS];
    assign sx = r_px[FRAC_BITS-1:0];
    assign sy = r_py[FRAC_BITS-1:0];
    assign tailx = (FRAC_BITS+2)'(3) * (FRAC_BITS+2)'(ONE) - {1'b0, sx, 1'b0};
    assign taily = (FRAC_BITS+2)'(3) * (FRAC_BITS+2)'(ONE) - {1'b0, sy, 1'b0};
    assign prodx = r_sqx * tailx;
    assign prody = r_sqy * taily;
    assign omx = ONE - r_wx;
    assign omy = ONE - r_wy;
    assign mix = r_lo * omy + r_hi * r_wy;
    assign trial = {r_rem, r_num[NUM_W-1]};

    // zero octaves run one, above the limit saturate
    always_comb begin
        if (i_octaves == '0)
            nlim = OCT_W'(1);
        else if (i_octaves > OCT_W'(MAX_OCTAVES))
            nlim = OCT_W'(MAX_OCTAVES);
        else
            nlim = i_octaves;
    end

    assign o_status.last_oct = (r_oct == r_nlim - OCT_W'(1));
    assign o_status.div_last = (r_dcnt == DCNT_W'(NUM_W - 1));
    assign o_noise = (|r_num[NUM_W-1:NOISE_W]) ? '1 : r_num[NOISE_W-1:0];

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: begin
                r_x    <= i_x;
                r_y    <= i_y;
                r_nlim <= nlim;
            end
            CMD_SCALE: begin
                r_px  <= POS_W'(r_x * i_freq);
                r_py  <= POS_W'(r_y * i_freq);
                r_oct <= '0;
                r_acc <= '0;
                r_amp <= '0;
            end
            CMD_HASH: begin
                r_h0  <= PERM_ROM[yi + i_seed];
                r_h1  <= PERM_ROM[yi + 8'd1 + i_seed];
                r_sqx <= FRAC_BITS'(((2*FRAC_BITS)'(sx) * (2*FRAC_BITS)'(sx)) >> FRAC_BITS);
                r_sqy <= FRAC_BITS'(((2*FRAC_BITS)'(sy) * (2*FRAC_BITS)'(sy)) >> FRAC_BITS);
            end
            CMD_WEIGHT: begin
                r_c00 <= PERM_ROM[r_h0 + xi];
                r_c10 <= PERM_ROM[r_h0 + xi + 8'd1];
                r_c01 <= PERM_ROM[r_h1 + xi];
                r_c11 <= PERM_ROM[r_h1 + xi + 8'd1];
                r_wx  <= prodx[FRAC_BITS +: W_W];
                r_wy  <= prody[FRAC_BITS +: W_W];
            end
            CMD_BLEND: begin
                r_lo <= BLEND_W'(r_c00) * BLEND_W'(omx) + BLEND_W'(r_c10) * BLEND_W'(r_wx);
                r_hi <= BLEND_W'(r_c01) * BLEND_W'(omx) + BLEND_W'(r_c11) * BLEND_W'(r_wx);
            end
            CMD_MIX: begin
                r_v <= mix[FRAC_BITS +: BLEND_W];
            end
            CMD_ACC: begin
                r_acc <= r_acc + ACC_W'(r_v >> r_oct);
                r_amp <= r_amp + (AMP_W'(ONE) >> r_oct);
                r_px  <= {r_px[POS_W-2:0], 1'b0};
                r_py  <= {r_py[POS_W-2:0], 1'b0};
                r_oct <= r_oct + OCT_W'(1);
            end
            CMD_DIV_INIT: begin
                r_num  <= {r_acc, 8'd0};
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            CMD_DIV_STEP: begin
                if (trial >= {1'b0, r_amp}) begin
                    r_rem <= AMP_W'(trial - {1'b0, r_amp});
                    r_num <= {r_num[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= AMP_W'(trial);
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            CMD_NONE, CMD_OUT: ;
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/fractal_value_noise_2d.sv =====
// fractal_value_noise_2d: top level with config registers, result register and checks
// depends on fvn_pkg, fvn_ctrl, fvn_dp
//
// One input beat carries a sample point (x, y); one output beat returns its fractal value noise
// as an unsigned Q0.16 fraction. The point is scaled by freq_scale into a Q8.16 lattice position,
// and each octave reads four hashed corners, smoothstep-blends them, adds the blend at a halving
// weight and doubles the position. Each octave steps through S_HASH, S_WEIGHT, S_BLEND, S_MIX and
// S_ACC, and the final normalization is a restoring divider at one quotient bit a cycle. An item
// passes S_SCALE, the octave states once for each of N octaves (reset count 20), S_DIVI, S_DIV and
// S_HOLD. The block holds one item at a time; a finished result sits in the output register, so a
// new point is taken while the previous result waits for the sink. Configuration writes take
// effect for the next point and should be made while the block is idle.
module fractal_value_noise_2d (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: tdata = {y_coord[31:16], x_coord[15:0]}
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // master side: tdata = noise_value[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    // config write: index 0 freq_scale, 1 octave_count, 2 hash_seed
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [fvn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import fvn_pkg::*;

    logic [FREQ_W-1:0] r_freq;
    logic [OCT_W-1:0]  r_octaves;
    logic [SEED_W-1:0] r_seed;
    logic              r_m_valid;
    logic [NOISE_W-1:0] r_m_data;

    t_cmd        cmd;
    t_dp_status  status;
    logic        out_free;
    logic [NOISE_W-1:0] noise;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_m_valid || m_tready;
    assign m_tvalid    = r_m_valid;
    assign m_tdata     = r_m_data;

    // register file, writes beyond the list fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq    <= FREQ_RESET;
            r_octaves <= OCT_RESET;
            r_seed    <= SEED_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FREQ_SCALE:   r_freq    <= i_cfg_data[FREQ_W-1:0];
                CFG_OCTAVE_COUNT: r_octaves <= i_cfg_data[OCT_W-1:0];
                CFG_HASH_SEED:    r_seed    <= i_cfg_data[SEED_W-1:0];
                default: ;
            endcase
        end
    end

    // output register, decouples the sink from the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (cmd == CMD_OUT) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd == CMD_OUT) begin
            r_m_data <= noise;
        end
    end

    fvn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_in_ready (s_tready),
        .o_cmd      (cmd)
    );

    fvn_dp u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_x       (s_tdata[15:0]),
        .i_y       (s_tdata[31:16]),
        .i_freq    (r_freq),
        .i_octaves (r_octaves),
        .i_seed    (r_seed),
        .o_status  (status),
        .o_noise   (noise)
    );

`ifndef ASSERT_OFF
    // a taken point blocks the input until its result is produced
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after a beat");

    // a new result only appears from the sequencer's hand-off
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(cmd == CMD_OUT))
        else $error("result raised without hand-off");

    // a hand-off never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd == CMD_OUT |-> out_free)
        else $error("result overwritten");
`endif

endmodule
